// File: rtl/core/jel_pkg.sv
// Package for the Josephus elimination order block.
// Holds the field widths, the parameter defaults and the sequencer states.
// No dependencies.
package jel_pkg;

  localparam int unsigned POS_W             = 7;
  localparam int unsigned DEF_MAX_PEOPLE    = 64;
  localparam int unsigned DEF_STEP_WIDTH    = 10;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BUILD,
    ST_MOD,
    ST_PRIME,
    ST_WALK,
    ST_EMIT,
    ST_FINAL
  } jel_state_e;

endpackage

// File: rtl/core/jel_link_ram.sv
// Next-link table of the ring: one write port and one read port.
// Read data is registered, so it arrives in the cycle after the address.
// No dependencies.
module jel_link_ram #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [AW-1:0] wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [AW-1:0] rdata_o
);

  logic [AW-1:0] mem [DEPTH];
  logic [AW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/josephus_elimination_order.sv
// Josephus elimination order: top level with the ring sequencer.
// Depends on jel_pkg and jel_link_ram.
//
// Channel  Direction  Handshake              Payload
// in       request    in_valid_i/in_ready_o  people_count_i, start_position_i, step_count_i
// out      result     out_valid_o/out_ready_i removed_position_o, last_of_run_o
//
// A request with n people and step m first builds the ring of n links, then
// reduces the start position by one subtraction of n per full wrap, then
// counts m people along the ring for each removed person, one step per cycle
// through the link memory read port, and last emits the survivor. A rejected
// request is dropped and the block stays idle.
// Reset clears the sequencer; the link memory is rebuilt by every request that is not rejected.
// A stalled result holds the sequencer; no request is taken until the run ends.
module josephus_elimination_order
  import jel_pkg::*;
#(
  parameter int unsigned MAX_PEOPLE = DEF_MAX_PEOPLE,
  parameter int unsigned STEP_WIDTH = DEF_STEP_WIDTH
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [POS_W-1:0]      people_count_i,
  input  logic [POS_W-1:0]      start_position_i,
  input  logic [STEP_WIDTH-1:0] step_count_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [POS_W-1:0]      removed_position_o,
  output logic                  last_of_run_o
);

  localparam int unsigned IDX_W = (MAX_PEOPLE > 1) ? $clog2(MAX_PEOPLE) : 1;
  localparam int unsigned CW    = ((IDX_W > POS_W) ? IDX_W : POS_W) + 1;

  jel_state_e state_q, state_d;

  logic [POS_W-1:0]      n_q, n_d;
  logic [POS_W-1:0]      r_q, r_d;
  logic [POS_W-1:0]      rem_q, rem_d;
  logic [STEP_WIDTH-1:0] step_q, step_d;
  logic [STEP_WIDTH-1:0] cnt_q, cnt_d;
  logic [IDX_W-1:0]      k_q, k_d;
  logic [IDX_W-1:0]      cur_q, cur_d;
  logic [IDX_W-1:0]      prev_q, prev_d;

  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  logic [IDX_W-1:0] ram_wdata;
  logic             ram_re;
  logic [IDX_W-1:0] ram_raddr;
  logic [IDX_W-1:0] ram_rdata;

  logic in_acc;
  logic out_acc;
  logic req_ok;
  logic build_last;
  logic walk_done;

  jel_link_ram #(
    .DEPTH (MAX_PEOPLE),
    .AW    (IDX_W)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = (state_q == ST_EMIT) || (state_q == ST_FINAL);
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_acc     = out_valid_o && out_ready_i;

  assign req_ok = (people_count_i != '0) &&
                  (32'(people_count_i) <= 32'(MAX_PEOPLE)) &&
                  (step_count_i != '0);
  assign build_last = (CW'(k_q) + CW'(1)) == CW'(n_q);
  assign walk_done  = (cnt_q == step_q);

  assign removed_position_o = POS_W'(CW'(cur_q) + CW'(1));
  assign last_of_run_o      = (state_q == ST_FINAL);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc && req_ok) begin
          state_d = ST_BUILD;
        end
      end
      ST_BUILD: begin
        if (build_last) begin
          state_d = ST_MOD;
        end
      end
      ST_MOD: begin
        if (r_q < n_q) begin
          state_d = (n_q == POS_W'(1)) ? ST_FINAL : ST_PRIME;
        end
      end
      ST_PRIME: begin
        state_d = ST_WALK;
      end
      ST_WALK: begin
        if (walk_done) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_acc) begin
          state_d = (rem_q == POS_W'(2)) ? ST_FINAL : ST_PRIME;
        end
      end
      ST_FINAL: begin
        if (out_acc) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    n_d       = n_q;
    r_d       = r_q;
    rem_d     = rem_q;
    step_d    = step_q;
    cnt_d     = cnt_q;
    k_d       = k_q;
    cur_d     = cur_q;
    prev_d    = prev_q;
    ram_we    = 1'b0;
    ram_waddr = k_q;
    ram_wdata = '0;
    ram_re    = 1'b0;
    ram_raddr = cur_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc && req_ok) begin
          n_d    = people_count_i;
          r_d    = (start_position_i == '0) ? '0 : start_position_i - POS_W'(1);
          step_d = step_count_i;
          k_d    = '0;
        end
      end
      ST_BUILD: begin
        ram_we    = 1'b1;
        ram_waddr = k_q;
        ram_wdata = build_last ? '0 : k_q + IDX_W'(1);
        k_d       = k_q + IDX_W'(1);
      end
      ST_MOD: begin
        if (r_q >= n_q) begin
          r_d = r_q - n_q;
        end else begin
          cur_d  = IDX_W'(r_q);
          prev_d = (r_q == '0) ? IDX_W'(n_q - POS_W'(1)) : IDX_W'(r_q - POS_W'(1));
          rem_d  = n_q;
        end
      end
      ST_PRIME: begin
        ram_re    = 1'b1;
        ram_raddr = cur_q;
        cnt_d     = STEP_WIDTH'(1);
      end
      ST_WALK: begin
        if (!walk_done) begin
          prev_d    = cur_q;
          cur_d     = ram_rdata;
          ram_re    = 1'b1;
          ram_raddr = ram_rdata;
          cnt_d     = cnt_q + STEP_WIDTH'(1);
        end
      end
      ST_EMIT: begin
        if (out_acc) begin
          ram_we    = 1'b1;
          ram_waddr = prev_q;
          ram_wdata = ram_rdata;
          cur_d     = ram_rdata;
          rem_d     = rem_q - POS_W'(1);
        end
      end
      ST_FINAL: begin
        if (out_acc) begin
          rem_d = '0;
        end
      end
      default: begin
        rem_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      rem_q   <= '0;
      cnt_q   <= '0;
      cur_q   <= '0;
      prev_q  <= '0;
    end else begin
      state_q <= state_d;
      rem_q   <= rem_d;
      cnt_q   <= cnt_d;
      cur_q   <= cur_d;
      prev_q  <= prev_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q    <= n_d;
    r_q    <= r_d;
    step_q <= step_d;
    k_q    <= k_d;
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("Request taken while a result is pending.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && last_of_run_o) |-> (rem_q == POS_W'(1)))
    else $error("Survivor flagged while more than one person remains.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WALK) |-> (cnt_q <= step_q))
    else $error("Walk counter ran past the step count.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && last_of_run_o) |=> in_ready_o)
    else $error("Block not ready after the end of a run.");

endmodule

// File: verif/tb_josephus_elimination_order.sv
`timescale 1ns / 1ps
// Testbench for josephus_elimination_order: directed table plus random requests,
// with each removal order checked against a ring predictor in the bench or, for one-person rows, the table.
// Depends on jel_pkg and the josephus_elimination_order RTL.
module tb_josephus_elimination_order;
  import jel_pkg::*;

  localparam int unsigned MAX_N      = DEF_MAX_PEOPLE;
  localparam int unsigned STEP_W     = DEF_STEP_WIDTH;
  localparam int unsigned N_RANDOM   = 84;
  localparam int unsigned IDLE_LIMIT = 20000;
  localparam int unsigned HOLD_LEN   = 400;

  typedef struct packed {
    logic [POS_W-1:0] pos;
    logic             last;
  } removal_t;

  typedef enum logic [1:0] {
    ROW_MODEL,
    ROW_REJECT,
    ROW_LONE
  } row_kind_e;

  typedef struct packed {
    logic [POS_W-1:0]  people;
    logic [POS_W-1:0]  start;
    logic [STEP_W-1:0] step;
    row_kind_e         kind;
    logic [POS_W-1:0]  lone_pos;
  } row_t;

  row_t directed_rows [0:16] = '{
    '{7'd1,   7'd1,   10'd1,    ROW_LONE,   7'd1},
    '{7'd0,   7'd5,   10'd3,    ROW_REJECT, 7'd0},
    '{7'd65,  7'd1,   10'd1,    ROW_REJECT, 7'd0},
    '{7'd127, 7'd127, 10'd1023, ROW_REJECT, 7'd0},
    '{7'd5,   7'd1,   10'd0,    ROW_REJECT, 7'd0},
    '{7'd1,   7'd127, 10'd1023, ROW_LONE,   7'd1},
    '{7'd5,   7'd0,   10'd2,    ROW_MODEL,  7'd0},
    '{7'd5,   7'd12,  10'd3,    ROW_MODEL,  7'd0},
    '{7'd64,  7'd64,  10'd1,    ROW_MODEL,  7'd0},
    '{7'd64,  7'd1,   10'd1023, ROW_MODEL,  7'd0},
    '{7'd2,   7'd2,   10'd2,    ROW_MODEL,  7'd0},
    '{7'd7,   7'd3,   10'd512,  ROW_MODEL,  7'd0},
    '{7'd41,  7'd1,   10'd3,    ROW_MODEL,  7'd0},
    '{7'd64,  7'd127, 10'd2,    ROW_MODEL,  7'd0},
    '{7'd10,  7'd64,  10'd1022, ROW_MODEL,  7'd0},
    '{7'd3,   7'd96,  10'd5,    ROW_MODEL,  7'd0},
    '{7'd6,   7'd6,   10'd6,    ROW_MODEL,  7'd0}
  };

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid;
  logic              in_ready_o;
  logic [POS_W-1:0]  people_count;
  logic [POS_W-1:0]  start_position;
  logic [STEP_W-1:0] step_count;
  logic              out_valid_o;
  logic              out_ready;
  logic [POS_W-1:0]  removed_position_o;
  logic              last_of_run_o;

  removal_t    removal_q [$];
  int unsigned ring_next [MAX_N];
  int unsigned cur_idx;
  int unsigned prev_idx;
  int unsigned left_in_ring;

  int unsigned requests_sent;
  int unsigned rejects_sent;
  int unsigned results_checked;
  int unsigned error_count;
  int unsigned idle_cycles;
  int unsigned hold_left;
  int unsigned stall_left;
  bit          hold_done;

  josephus_elimination_order u_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid),
    .in_ready_o         (in_ready_o),
    .people_count_i     (people_count),
    .start_position_i   (start_position),
    .step_count_i       (step_count),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready),
    .removed_position_o (removed_position_o),
    .last_of_run_o      (last_of_run_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Walks the ring one count at a time and queues every removal in order.
  task automatic predict_removals(input logic [POS_W-1:0] n_in,
                                  input logic [POS_W-1:0] s_in,
                                  input logic [STEP_W-1:0] m_in);
    int unsigned n;
    int unsigned k;
    if (n_in == 0 || n_in > MAX_N || m_in == 0) return;
    n = n_in;
    for (k = 0; k < n; k++) ring_next[k] = (k + 1 < n) ? k + 1 : 0;
    cur_idx = (s_in == 0) ? 0 : (s_in - 1) % n;
    prev_idx = (cur_idx + n - 1) % n;
    left_in_ring = n;
    while (left_in_ring > 1) begin
      for (k = 1; k < m_in; k++) begin
        prev_idx = cur_idx;
        cur_idx = ring_next[cur_idx];
      end
      removal_q.push_back('{pos: POS_W'(cur_idx + 1), last: 1'b0});
      ring_next[prev_idx] = ring_next[cur_idx];
      cur_idx = ring_next[cur_idx];
      left_in_ring--;
    end
    removal_q.push_back('{pos: POS_W'(cur_idx + 1), last: 1'b1});
  endtask

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 50) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_request(input row_t row);
    in_valid <= 1'b1;
    people_count <= row.people;
    start_position <= row.start;
    step_count <= row.step;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    requests_sent++;
    case (row.kind)
      ROW_REJECT: begin
        rejects_sent++;
      end
      ROW_LONE: begin
        removal_q.push_back('{pos: row.lone_pos, last: 1'b1});
      end
      default: begin
        if (row.people == 0 || row.people > MAX_N || row.step == 0) rejects_sent++;
        predict_removals(row.people, row.start, row.step);
      end
    endcase
  endtask

  task automatic make_random(output row_t row);
    int unsigned r;
    row.kind = ROW_MODEL;
    row.lone_pos = '0;
    row.start = POS_W'($urandom_range(0, 127));
    r = $urandom_range(99);
    if (r < 75) row.people = POS_W'($urandom_range(1, 12));
    else if (r < 92) row.people = POS_W'($urandom_range(13, 40));
    else row.people = POS_W'($urandom_range(41, 64));
    r = $urandom_range(99);
    if (r < 70) row.step = STEP_W'($urandom_range(1, 30));
    else if (r < 90 || row.people > 16) row.step = STEP_W'($urandom_range(31, 200));
    else row.step = STEP_W'($urandom_range(201, 1023));
    r = $urandom_range(99);
    if (r < 3) row.people = '0;
    else if (r < 7) row.people = POS_W'($urandom_range(65, 127));
    else if (r < 10) row.step = '0;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready) begin
      if (removal_q.size() == 0) begin
        $display("%0t: unexpected result position %0d last %0b",
                 $time, removed_position_o, last_of_run_o);
        error_count++;
      end else begin
        if (removal_q[0].pos !== removed_position_o) begin
          $display("%0t: removed_position expected %0d actual %0d",
                   $time, removal_q[0].pos, removed_position_o);
          error_count++;
        end
        if (removal_q[0].last !== last_of_run_o) begin
          $display("%0t: last_of_run expected %0b actual %0b",
                   $time, removal_q[0].last, last_of_run_o);
          error_count++;
        end
        void'(removal_q.pop_front());
      end
      results_checked++;
    end
  end

  // The long hold-off comes once, while requests are still being offered.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (!hold_done && results_checked >= 40) begin
        hold_done = 1'b1;
        hold_left = HOLD_LEN - 1;
        out_ready <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        stall_left = ((results_checked % 100) < 25) ? 0 : pick_gap();
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && in_ready_o) || (out_valid_o && out_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
          $display("%0t: no request or result moved for %0d cycles", $time, idle_cycles);
          $display("SCOREBOARD MISMATCH");
          $finish;
        end
      end
    end
  end

  initial begin
    row_t        row;
    int unsigned i;
    int unsigned gap;
    clk_i = 1'b0;
    rst_ni = 1'b0;
    in_valid = 1'b0;
    out_ready = 1'b0;
    people_count = '0;
    start_position = '0;
    step_count = '0;
    requests_sent = 0;
    rejects_sent = 0;
    results_checked = 0;
    error_count = 0;
    idle_cycles = 0;
    hold_left = 0;
    stall_left = 0;
    hold_done = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (i = 0; i < $size(directed_rows); i++) begin
      send_request(directed_rows[i]);
      gap = pick_gap();
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end

    for (i = 0; i < N_RANDOM; i++) begin
      make_random(row);
      send_request(row);
      gap = ((i % 20) < 6) ? 0 : pick_gap();
      if (i == N_RANDOM / 2) begin
        in_valid <= 1'b0;
        while (removal_q.size() != 0) @(posedge clk_i);
      end else if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    in_valid <= 1'b0;

    while (removal_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    $display("Covered %0d requests (%0d rejected) and %0d removals, including rings up to",
             requests_sent, rejects_sent, results_checked);
    $display("64 people, steps up to 1023, wrapped starts and a long result stall.");
    if (error_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/core/jel_pkg.sv
rtl/core/jel_link_ram.sv
rtl/core/josephus_elimination_order.sv
verif/tb_josephus_elimination_order.sv
